// ===== rtl/core/json_array_element_scanner_macros.svh =====
// Assertion macros used by the scanner top level.
`ifndef JSON_ARRAY_ELEMENT_SCANNER_MACROS_SVH
`define JSON_ARRAY_ELEMENT_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define JAES_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define JAES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/jaes_pkg.sv =====
// Types and constants shared by the JSON array element scanner.
package jaes_pkg;

    // character codes
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOT_ARR  = 3'd1;
    localparam logic [2:0] ST_UNTERM   = 3'd2;
    localparam logic [2:0] ST_TOO_DEEP = 3'd3;
    localparam logic [2:0] ST_TOO_LONG = 3'd4;

    // scan phase
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SCAN  = 2'd1;
    localparam logic [1:0] PH_DRAIN = 2'd2;

    // target element phase
    localparam logic [1:0] TP_WAIT   = 2'd0;
    localparam logic [1:0] TP_SEEK   = 2'd1;
    localparam logic [1:0] TP_INSIDE = 2'd2;
    localparam logic [1:0] TP_DONE   = 2'd3;

    // element kind
    localparam logic [1:0] EK_SCALAR = 2'd0;
    localparam logic [1:0] EK_STRING = 2'd1;
    localparam logic [1:0] EK_NESTED = 2'd2;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    localparam int CNT_W = 16;

    // classified byte
    typedef struct packed {
        logic last;
        logic lbrack;
        logic rbrack;
        logic lbrace;
        logic rbrace;
        logic comma;
        logic quote;
        logic bslash;
        logic space;
    } t_q_entry;

    typedef struct packed {
        logic            valid;
        logic            full;
        logic [QC_W-1:0] count;
    } t_q_status;

    typedef struct packed {
        logic [2:0]       status;
        logic [CNT_W-1:0] elem_end;
        logic [CNT_W-1:0] elem_start;
        logic             found;
        logic [CNT_W-1:0] elem_count;
    } t_result;

endpackage

// ===== rtl/core/jaes_front.sv =====
// Front end: classifies each incoming byte for the scan engine.
module jaes_front (
    input  logic              [7:0] i_byte,
    input  logic                    i_last,
    output jaes_pkg::t_q_entry      o_entry
);
    import jaes_pkg::*;

    always_comb begin
        o_entry.last   = i_last;
        o_entry.lbrack = (i_byte == CH_LBRACK);
        o_entry.rbrack = (i_byte == CH_RBRACK);
        o_entry.lbrace = (i_byte == CH_LBRACE);
        o_entry.rbrace = (i_byte == CH_RBRACE);
        o_entry.comma  = (i_byte == CH_COMMA);
        o_entry.quote  = (i_byte == CH_QUOTE);
        o_entry.bslash = (i_byte == CH_BSLASH);
        o_entry.space  = (i_byte == CH_SPACE) || (i_byte == CH_TAB) ||
                         (i_byte == CH_LF) || (i_byte == CH_CR);
    end
endmodule

// ===== rtl/core/jaes_queue.sv =====
// Short FIFO of classified bytes between front and back.
module jaes_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  jaes_pkg::t_q_entry  i_entry,
    input  logic                i_pop,
    output jaes_pkg::t_q_entry  o_head,
    output jaes_pkg::t_q_status o_status
);
    import jaes_pkg::*;

    t_q_entry        r_mem [QDEPTH];
    logic [QA_W-1:0] r_wr;
    logic [QA_W-1:0] r_rd;
    logic [QC_W-1:0] r_count;
    logic            w_push;
    logic            w_pop;

    assign w_push = i_push && (r_count != QC_W'(QDEPTH));
    assign w_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + QA_W'(1);
            if (w_pop)  r_rd <= r_rd + QA_W'(1);
            if (w_push && !w_pop)      r_count <= r_count + QC_W'(1);
            else if (w_pop && !w_push) r_count <= r_count - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_entry;
    end

    assign o_head         = r_mem[r_rd];
    assign o_status.valid = (r_count != '0);
    assign o_status.full  = (r_count == QC_W'(QDEPTH));
    assign o_status.count = r_count;
endmodule

// ===== rtl/core/jaes_back.sv =====
// Back end: quote, escape and depth tracking, element location, result register.
module jaes_back #(
    parameter int MAX_DEPTH   = 15,
    parameter int OFFSET_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    input  jaes_pkg::t_q_entry i_head,
    input  logic               i_head_valid,
    output logic               o_pop,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output jaes_pkg::t_result  o_res
);
    import jaes_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [CNT_W-1:0]       CNT_MAX = {CNT_W{1'b1}};

    logic [CNT_W-1:0]       r_target;
    logic [1:0]             r_phase,  n_phase;
    logic [OFFSET_BITS-1:0] r_off,    n_off;
    logic                   r_inq,    n_inq;
    logic                   r_esc,    n_esc;
    logic [DEPTH_W-1:0]     r_depth,  n_depth;
    logic [CNT_W-1:0]       r_comma,  n_comma;
    logic                   r_seen,   n_seen;
    logic [OFFSET_BITS-1:0] r_start,  n_start;
    logic [OFFSET_BITS-1:0] r_end,    n_end;
    logic [1:0]             r_tphase, n_tphase;
    logic [1:0]             r_kind,   n_kind;
    logic                   r_out_valid;
    t_result                r_out;

    logic             w_emit;
    logic [2:0]       w_status;
    logic             w_top_close;
    logic             w_open;
    logic             w_close;
    logic [CNT_W:0]   w_sum;
    logic [31:0]      w_start_ext;
    logic [31:0]      w_end_ext;
    logic             w_found;
    t_result          w_res;

    assign o_pop = i_head_valid && (!r_out_valid || i_res_ready);

    assign w_open  = i_head.lbrack || i_head.lbrace;
    assign w_close = i_head.rbrack || i_head.rbrace;
    assign w_top_close = i_head.rbrack && (r_depth == '0);

    always_comb begin
        n_phase  = r_phase;
        n_off    = r_off;
        n_inq    = r_inq;
        n_esc    = r_esc;
        n_depth  = r_depth;
        n_comma  = r_comma;
        n_seen   = r_seen;
        n_start  = r_start;
        n_end    = r_end;
        n_tphase = r_tphase;
        n_kind   = r_kind;
        w_emit   = 1'b0;
        w_status = ST_OK;

        if (o_pop) begin
            case (r_phase)
                PH_DRAIN: begin
                    if (i_head.last) n_phase = PH_IDLE;
                end
                PH_SCAN: begin
                    if (r_off == OFF_MAX) begin
                        w_emit   = 1'b1;
                        w_status = ST_TOO_LONG;
                    end else begin
                        n_off = r_off + OFFSET_BITS'(1);
                        if (r_tphase == TP_WAIT && r_comma == r_target) n_tphase = TP_SEEK;

                        if (r_esc) begin
                            n_esc = 1'b0;
                        end else if (r_inq) begin
                            if (i_head.bslash) begin
                                n_esc = 1'b1;
                            end else if (i_head.quote) begin
                                n_inq = 1'b0;
                                if (n_tphase == TP_INSIDE && r_kind == EK_STRING &&
                                    r_depth == '0) begin
                                    n_end    = r_off + OFFSET_BITS'(1);
                                    n_tphase = TP_DONE;
                                end
                            end
                        end else if (!i_head.space) begin
                            if (r_comma == '0 && !i_head.comma && !w_top_close)
                                n_seen = 1'b1;
                            if (i_head.comma && r_depth == '0) begin
                                if (n_tphase == TP_INSIDE && r_kind == EK_SCALAR) begin
                                    n_end    = r_off;
                                    n_tphase = TP_DONE;
                                end
                                if (r_comma != CNT_MAX) n_comma = r_comma + CNT_W'(1);
                            end else if (w_top_close) begin
                                if (n_tphase == TP_INSIDE && r_kind == EK_SCALAR) begin
                                    n_end    = r_off;
                                    n_tphase = TP_DONE;
                                end
                                w_emit = 1'b1;
                            end else if (!i_head.comma) begin
                                if (n_tphase == TP_SEEK) begin
                                    n_start  = r_off;
                                    n_tphase = TP_INSIDE;
                                    if (i_head.quote)  n_kind = EK_STRING;
                                    else if (w_open)   n_kind = EK_NESTED;
                                    else               n_kind = EK_SCALAR;
                                end
                                if (w_open) begin
                                    if (r_depth >= DEPTH_W'(MAX_DEPTH)) begin
                                        w_emit   = 1'b1;
                                        w_status = ST_TOO_DEEP;
                                    end else begin
                                        n_depth = r_depth + DEPTH_W'(1);
                                    end
                                end else if (w_close && r_depth != '0) begin
                                    n_depth = r_depth - DEPTH_W'(1);
                                    if (n_depth == '0 && n_tphase == TP_INSIDE &&
                                        n_kind == EK_NESTED) begin
                                        n_end    = r_off + OFFSET_BITS'(1);
                                        n_tphase = TP_DONE;
                                    end
                                end else if (i_head.quote) begin
                                    n_inq = 1'b1;
                                end
                            end
                        end
                        if (!w_emit && i_head.last) begin
                            w_emit   = 1'b1;
                            w_status = ST_UNTERM;
                        end
                    end
                end
                default: begin
                    // waiting for the opening bracket of a new frame
                    n_off    = '0;
                    n_inq    = 1'b0;
                    n_esc    = 1'b0;
                    n_depth  = '0;
                    n_comma  = '0;
                    n_seen   = 1'b0;
                    n_start  = '0;
                    n_end    = '0;
                    n_tphase = TP_WAIT;
                    n_kind   = EK_SCALAR;
                    if (!i_head.lbrack) begin
                        w_emit   = 1'b1;
                        w_status = ST_NOT_ARR;
                    end else begin
                        n_phase = PH_SCAN;
                        n_off   = OFFSET_BITS'(1);
                        if (i_head.last) begin
                            w_emit   = 1'b1;
                            w_status = ST_UNTERM;
                        end
                    end
                end
            endcase
        end

        // result from the post-update state
        w_sum       = {1'b0, n_comma} + {{CNT_W{1'b0}}, n_seen};
        w_found     = (w_status == ST_OK) && (n_tphase == TP_DONE);
        w_start_ext = 32'(n_start);
        w_end_ext   = 32'(n_end);
        w_res.elem_count = w_sum[CNT_W] ? CNT_MAX : w_sum[CNT_W-1:0];
        w_res.found      = w_found;
        w_res.elem_start = w_found ? w_start_ext[CNT_W-1:0] : '0;
        w_res.elem_end   = w_found ? w_end_ext[CNT_W-1:0] : '0;
        w_res.status     = w_status;

        if (w_emit) begin
            n_off    = '0;
            n_inq    = 1'b0;
            n_esc    = 1'b0;
            n_depth  = '0;
            n_comma  = '0;
            n_seen   = 1'b0;
            n_start  = '0;
            n_end    = '0;
            n_tphase = TP_WAIT;
            n_kind   = EK_SCALAR;
            n_phase  = i_head.last ? PH_IDLE : PH_DRAIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_phase     <= PH_IDLE;
            r_off       <= '0;
            r_inq       <= 1'b0;
            r_esc       <= 1'b0;
            r_depth     <= '0;
            r_comma     <= '0;
            r_seen      <= 1'b0;
            r_start     <= '0;
            r_end       <= '0;
            r_tphase    <= TP_WAIT;
            r_kind      <= EK_SCALAR;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_target <= i_cfg_wdata;
            r_phase  <= n_phase;
            r_off    <= n_off;
            r_inq    <= n_inq;
            r_esc    <= n_esc;
            r_depth  <= n_depth;
            r_comma  <= n_comma;
            r_seen   <= n_seen;
            r_start  <= n_start;
            r_end    <= n_end;
            r_tphase <= n_tphase;
            r_kind   <= n_kind;
            if (o_pop && w_emit)  r_out_valid <= 1'b1;
            else if (i_res_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) r_out <= w_res;
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
endmodule

// ===== rtl/core/json_array_element_scanner.sv =====
// Top level of the JSON array element scanner: front classifier, queue, scan engine.
// Throughput: one byte request per cycle while results are taken; a waiting result stalls
//   the scan engine, and the input stops once the two-entry byte queue is full.
// Path: the byte request that ends a frame is written into the byte queue, and the scan
//   engine, once it pops that byte, loads the result into the output register.
// Reset: synchronous, active low; clears queue, scan state, target index and output valid.
`include "json_array_element_scanner_macros.svh"

module json_array_element_scanner #(
    parameter int MAX_DEPTH   = 15,
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: target_index
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // byte requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    // result requests
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // [15:0] element_count, [16] found,
                                   // [32:17] element_start, [48:33] element_end,
                                   // [51:49] status, [55:52] zero
);
    import jaes_pkg::*;

    t_q_entry  w_entry;
    t_q_entry  w_head;
    t_q_status w_qstat;
    logic      w_pop;
    t_result   w_res;
    logic      w_in_accept;

    // Front: classify the byte; the queue takes it whenever it has room.
    jaes_front u_front (
        .i_byte  (s_tdata),
        .i_last  (s_tlast),
        .o_entry (w_entry)
    );

    assign s_tready    = !w_qstat.full;
    assign w_in_accept = s_tvalid && s_tready;

    // Two-entry queue decouples byte intake from the scan engine's output stalls.
    jaes_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_in_accept),
        .i_entry  (w_entry),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_qstat)
    );

    // Back: one queued byte per cycle while the output register is free or draining.
    jaes_back #(
        .MAX_DEPTH   (MAX_DEPTH),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_head       (w_head),
        .i_head_valid (w_qstat.valid),
        .o_pop        (w_pop),
        .o_res_valid  (m_tvalid),
        .i_res_ready  (m_tready),
        .o_res        (w_res)
    );

    assign m_tdata = {4'b0000, w_res};

    // Checks
    `JAES_ASSERT_NOW(a_q_bound, i_clk, i_rst_n, 1'b1, w_qstat.count <= QC_W'(QDEPTH), "queue count beyond depth")
    `JAES_ASSERT_NEXT(a_q_fill, i_clk, i_rst_n, w_in_accept && !w_qstat.valid, w_qstat.valid, "accepted byte not queued")
    `JAES_ASSERT_NOW(a_found_ok, i_clk, i_rst_n, m_tvalid && w_res.found, w_res.status == ST_OK, "found with error status")
    `JAES_ASSERT_NOW(a_no_pop_stall, i_clk, i_rst_n, w_pop, !m_tvalid || m_tready, "pop while result stalled")

endmodule
